>>> hw/rtl/assert_macros.svh
// Assertion macros included by the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/sgsr_pkg.sv
// Constants and types of the scaled glyph span rasterizer.
`timescale 1ns / 1ps
package sgsr_pkg;

  localparam int SCREEN_WIDTH   = 800;
  localparam int SCREEN_HEIGHT  = 480;
  localparam int MAX_SCALE      = 8;
  localparam int MAX_GLYPH_SIZE = 64;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_BASELINE_Y   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_FACTOR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PEN_COLOR    = 2'd2;

  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_BYTE   = 1'b1;
  localparam logic KIND_SPAN   = 1'b0;
  localparam logic KIND_CURSOR = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [8:0]  span_y;
    logic [9:0]  span_x_first;
    logic [9:0]  span_x_last;
    logic [15:0] fill_color;
    logic [15:0] next_cursor_x;
  } sgsr_res_t;

endpackage

>>> hw/rtl/scaled_glyph_span_rasterizer.sv
// Scaled glyph span rasterizer: glyph header and bitmap bytes in, clipped spans out.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A header word is answered with one cursor report, held in the pending register and
// then moved to the output register; the next input word is taken once it has moved.
// A bitmap byte is loaded, then walked one bitmap column at a time inside the glyph
// width (at most eight columns); every set, horizontally visible column steps through
// scale rows, one span for each row on screen, and a final step flushes the last span;
// the input is not ready in the meantime. A single sequencer walks columns and scaled
// rows and emits at most one span per cycle. Spans come out in column order, then row
// order, and tlast marks the final word caused by each input word. Output stalls hold
// the sequencer.
module scaled_glyph_span_rasterizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // cursor_x[15:0], glyph_x_offset[23:16], glyph_y_offset[31:24], glyph_width[38:32],
  // glyph_height[45:39], glyph_advance[53:46], bitmap_byte[61:54], zeros above
  input  logic [sgsr_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // span_y[8:0], span_x_first[18:9], span_x_last[28:19], fill_color[44:29],
  // next_cursor_x[60:45], zeros above
  output logic [sgsr_pkg::OUT_DATA_W-1:0]   out_tdata,
  // kind[0]
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgsr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sgsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sgsr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BIT   = 2'd1;
  localparam logic [1:0] ST_ROW   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam logic [6:0]  GLYPH_MAX = 7'(MAX_GLYPH_SIZE);
  localparam logic [3:0]  SCALE_MAX = 4'(MAX_SCALE);
  localparam logic signed [16:0] X_MAX = 17'(SCREEN_WIDTH - 1);
  localparam logic [15:0] Y_LIM = 16'(SCREEN_HEIGHT);

  // configuration
  logic [15:0] baseline_y_r;
  logic [3:0]  scale_factor_r;
  logic [15:0] pen_color_r;

  // glyph state
  logic [15:0] draw_x_r, draw_x_nxt;
  logic [15:0] draw_y_r, draw_y_nxt;
  logic [6:0]  box_width_r, box_width_nxt;
  logic [6:0]  box_height_r, box_height_nxt;
  logic [6:0]  row_count_r, row_count_nxt;
  logic [2:0]  byte_in_row_r, byte_in_row_nxt;
  logic        glyph_active_r, glyph_active_nxt;

  // sequencer
  logic [1:0]  state_r, state_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [6:0]  col_r, col_nxt;
  logic [15:0] x_r, x_nxt;
  logic [15:0] ybase_r, ybase_nxt;
  logic [2:0]  sy_r, sy_nxt;
  logic [9:0]  lo_r, lo_nxt;
  logic [9:0]  hi_r, hi_nxt;

  // pending result and output register
  logic        hold_v_r, hold_v_nxt;
  sgsr_res_t   hold_r, hold_nxt;
  logic        out_v_r, out_v_nxt;
  sgsr_res_t   out_r, out_nxt;
  logic        out_last_r, out_last_nxt;

  logic [3:0]  s_eff;
  logic        out_free;
  logic        in_acc;

  // header fields
  logic [15:0] cx;
  logic signed [7:0] xo, yo;
  logic [6:0]  gw, gh, gw_sat, gh_sat;
  logic [7:0]  adv;
  logic signed [12:0] xo_sc, yo_sc;
  logic [11:0] adv_sc;
  logic [9:0]  col_sc;
  logic [10:0] row_sc;
  logic [3:0]  per_row;
  logic [3:0]  bir_inc;
  logic [6:0]  row_inc;

  // column and row evaluation
  logic signed [16:0] x_sx, hi_raw, lo_c, hi_c;
  logic        col_vis, col_end, pix_set;
  logic [15:0] y_cur;
  logic        y_ok, last_row;

  // assertion terms
  logic        hdr_acc, span_ok, report_pending;

  always_comb begin
    s_eff = scale_factor_r;
    if (scale_factor_r == 4'd0) begin
      s_eff = 4'd1;
    end else if (scale_factor_r > SCALE_MAX) begin
      s_eff = SCALE_MAX;
    end
  end

  assign out_free  = !out_v_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && !hold_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign cx  = in_tdata[15:0];
  assign xo  = $signed(in_tdata[23:16]);
  assign yo  = $signed(in_tdata[31:24]);
  assign gw  = in_tdata[38:32];
  assign gh  = in_tdata[45:39];
  assign adv = in_tdata[53:46];
  assign gw_sat = (gw > GLYPH_MAX) ? GLYPH_MAX : gw;
  assign gh_sat = (gh > GLYPH_MAX) ? GLYPH_MAX : gh;
  assign xo_sc  = 13'(xo) * 13'($signed({1'b0, s_eff}));
  assign yo_sc  = 13'(yo) * 13'($signed({1'b0, s_eff}));
  assign adv_sc = 12'(adv) * 12'(s_eff);
  assign col_sc = 10'({byte_in_row_r, 3'b000}) * 10'(s_eff);
  assign row_sc = 11'(row_count_r) * 11'(s_eff);
  assign per_row = 4'((box_width_r + 7'd7) >> 3);
  assign bir_inc = {1'b0, byte_in_row_r} + 4'd1;
  assign row_inc = row_count_r + 7'd1;

  assign x_sx    = 17'($signed(x_r));
  assign hi_raw  = x_sx + 17'(s_eff) - 17'sd1;
  assign lo_c    = x_r[15] ? 17'sd0 : x_sx;
  assign hi_c    = (hi_raw > X_MAX) ? X_MAX : hi_raw;
  assign pix_set = byte_r[3'd7 - bit_r];
  assign col_vis = pix_set && (lo_c <= hi_c);
  assign col_end = (col_r >= box_width_r);

  assign y_cur    = ybase_r + {13'd0, sy_r};
  assign y_ok     = !y_cur[15] && (y_cur < Y_LIM);
  assign last_row = (sy_r == 3'(s_eff - 4'd1));

  always_comb begin
    state_nxt        = state_r;
    draw_x_nxt       = draw_x_r;
    draw_y_nxt       = draw_y_r;
    box_width_nxt    = box_width_r;
    box_height_nxt   = box_height_r;
    row_count_nxt    = row_count_r;
    byte_in_row_nxt  = byte_in_row_r;
    glyph_active_nxt = glyph_active_r;
    byte_nxt         = byte_r;
    bit_nxt          = bit_r;
    col_nxt          = col_r;
    x_nxt            = x_r;
    ybase_nxt        = ybase_r;
    sy_nxt           = sy_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    hold_v_nxt       = hold_v_r;
    hold_nxt         = hold_r;
    out_v_nxt        = out_v_r && !out_tready;
    out_nxt          = out_r;
    out_last_nxt     = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == MODE_HEADER) begin
            draw_x_nxt       = cx + 16'(xo_sc);
            draw_y_nxt       = baseline_y_r + 16'(yo_sc);
            box_width_nxt    = gw_sat;
            box_height_nxt   = gh_sat;
            row_count_nxt    = 7'd0;
            byte_in_row_nxt  = 3'd0;
            glyph_active_nxt = (gw_sat != 7'd0) && (gh_sat != 7'd0);
            hold_v_nxt       = 1'b1;
            hold_nxt         = '{kind: KIND_CURSOR, span_y: 9'd0, span_x_first: 10'd0,
                                 span_x_last: 10'd0, fill_color: 16'd0,
                                 next_cursor_x: cx + 16'(adv_sc)};
            state_nxt        = ST_FLUSH;
          end else if (glyph_active_r) begin
            byte_nxt  = in_tdata[61:54];
            bit_nxt   = 3'd0;
            col_nxt   = {1'b0, byte_in_row_r, 3'b000};
            x_nxt     = draw_x_r + 16'(col_sc);
            ybase_nxt = draw_y_r + 16'(row_sc);
            state_nxt = ST_BIT;
            if (bir_inc >= per_row) begin
              byte_in_row_nxt = 3'd0;
              row_count_nxt   = row_inc;
              if (row_inc >= box_height_r) begin
                glyph_active_nxt = 1'b0;
              end
            end else begin
              byte_in_row_nxt = 3'(bir_inc);
            end
          end
        end
      end
      ST_BIT: begin
        if (col_end) begin
          state_nxt = ST_FLUSH;
        end else if (col_vis) begin
          lo_nxt    = lo_c[9:0];
          hi_nxt    = hi_c[9:0];
          sy_nxt    = 3'd0;
          state_nxt = ST_ROW;
        end else begin
          x_nxt   = x_r + 16'(s_eff);
          col_nxt = col_r + 7'd1;
          bit_nxt = bit_r + 3'd1;
          if (bit_r == 3'd7) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_ROW: begin
        if (!y_ok || !hold_v_r || out_free) begin
          if (y_ok) begin
            if (hold_v_r) begin
              out_v_nxt    = 1'b1;
              out_nxt      = hold_r;
              out_last_nxt = 1'b0;
            end
            hold_v_nxt = 1'b1;
            hold_nxt   = '{kind: KIND_SPAN, span_y: y_cur[8:0], span_x_first: lo_r,
                           span_x_last: hi_r, fill_color: pen_color_r,
                           next_cursor_x: 16'd0};
          end
          sy_nxt = sy_r + 3'd1;
          if (last_row) begin
            x_nxt   = x_r + 16'(s_eff);
            col_nxt = col_r + 7'd1;
            bit_nxt = bit_r + 3'd1;
            state_nxt = (bit_r == 3'd7) ? ST_FLUSH : ST_BIT;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_nxt      = hold_r;
          out_last_nxt = 1'b1;
          hold_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_y_r   <= 16'd0;
      scale_factor_r <= 4'd1;
      pen_color_r    <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_BASELINE_Y:   baseline_y_r   <= cfg_data;
        CFG_SCALE_FACTOR: scale_factor_r <= cfg_data[3:0];
        CFG_PEN_COLOR:    pen_color_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      draw_x_r       <= 16'd0;
      draw_y_r       <= 16'd0;
      box_width_r    <= 7'd0;
      box_height_r   <= 7'd0;
      row_count_r    <= 7'd0;
      byte_in_row_r  <= 3'd0;
      glyph_active_r <= 1'b0;
      hold_v_r       <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      draw_x_r       <= draw_x_nxt;
      draw_y_r       <= draw_y_nxt;
      box_width_r    <= box_width_nxt;
      box_height_r   <= box_height_nxt;
      row_count_r    <= row_count_nxt;
      byte_in_row_r  <= byte_in_row_nxt;
      glyph_active_r <= glyph_active_nxt;
      hold_v_r       <= hold_v_nxt;
      out_v_r        <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    bit_r      <= bit_nxt;
    col_r      <= col_nxt;
    x_r        <= x_nxt;
    ybase_r    <= ybase_nxt;
    sy_r       <= sy_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'd0, out_r.next_cursor_x, out_r.fill_color, out_r.span_x_last,
                       out_r.span_x_first, out_r.span_y};

  assign hdr_acc        = in_acc && (in_tuser == MODE_HEADER);
  assign span_ok        = (out_r.span_x_first <= out_r.span_x_last) &&
                          (out_r.span_y < 9'(SCREEN_HEIGHT));
  assign report_pending = hold_v_r && (hold_r.kind == KIND_CURSOR) && (state_r == ST_FLUSH);

  `ASSERT_NEVER(a_idle_no_hold, (state_r == ST_IDLE) && hold_v_r, "pending word left in idle")
  `ASSERT_CLK(a_span_order, out_v_r && (out_r.kind == KIND_SPAN) |-> span_ok, "bad span")
  `ASSERT_CLK(a_hdr_report, hdr_acc |=> report_pending, "header not answered")
  `ASSERT_CLK(a_row_bound, (state_r == ST_ROW) |-> ({1'b0, sy_r} < s_eff), "row past scale")

endmodule
